// ===== rtl/core/pwfs_pkg.sv =====
// package with constants and the protocol string table of the peer-wire frame splitter
`default_nettype none

package pwfs_pkg;

  localparam int PosW = 33;
  localparam int LenW = 32;

  localparam logic [7:0] ProtoLen = 8'd19;
  localparam logic [PosW-1:0] ProtoLenPos = 33'd19;
  localparam logic [PosW-1:0] HandshakeLastPos = 33'd67;
  localparam logic [PosW-1:0] PrefixLastPos = 33'd3;
  localparam logic [PosW-1:0] PrefixBytesPos = 33'd4;

  function automatic logic [7:0] proto_char(input logic [4:0] idx);
    logic [7:0] c;
    case (idx)
      5'd0:    c = 8'h42;
      5'd1:    c = 8'h69;
      5'd2:    c = 8'h74;
      5'd3:    c = 8'h54;
      5'd4:    c = 8'h6f;
      5'd5:    c = 8'h72;
      5'd6:    c = 8'h72;
      5'd7:    c = 8'h65;
      5'd8:    c = 8'h6e;
      5'd9:    c = 8'h74;
      5'd10:   c = 8'h20;
      5'd11:   c = 8'h70;
      5'd12:   c = 8'h72;
      5'd13:   c = 8'h6f;
      5'd14:   c = 8'h74;
      5'd15:   c = 8'h6f;
      5'd16:   c = 8'h63;
      5'd17:   c = 8'h6f;
      5'd18:   c = 8'h6c;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/peer_wire_frame_splitter.sv =====
// peer-wire frame splitter: marks frame boundaries in a received byte stream
//
// input channel: in_valid / in_stall carry rx_byte, one stream byte per transaction.
// output channel: out_valid / out_stall carry out_byte with frame_first, frame_last
// and frame_kind (on the last byte: 0 length-prefixed message, 1 handshake).
// a frame starting with 19 and the 19-byte protocol string is a 68-byte handshake;
// any other frame is a 4-byte big-endian length prefix plus that many bytes.
// each byte passes the input register, then the result register that holds the framing
// decision, before it appears on the output.
// throughput: one byte per cycle while out_stall stays low, set by the single pass of
// framing logic between the input register and the result register.
// reset (rst, synchronous) empties both registers and restarts at a frame start.
// when out_stall is high the result holds; the input register still takes one
// more byte, after which in_stall rises until the output drains.
`default_nettype none

module peer_wire_frame_splitter (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            frame_first,
  output logic            frame_last,
  output logic            frame_kind
);

  logic                      s1_valid;
  logic [7:0]                s1_byte;
  logic [pwfs_pkg::PosW-1:0] pos;
  logic [pwfs_pkg::PosW-1:0] pos_next;
  logic [pwfs_pkg::LenW-1:0] prefix;
  logic [pwfs_pkg::LenW-1:0] prefix_next;
  logic [pwfs_pkg::PosW-1:0] end_pos;
  logic                      hc;
  logic                      hc_new;
  logic                      advance;
  logic                      is_first;
  logic                      last_hs;
  logic                      last_len;
  logic                      is_last;
  logic [4:0]                char_idx;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign char_idx = pos[4:0] - 5'd1;
  assign is_first = (pos == '0);

  always_comb begin
    if (is_first) begin
      hc_new = (s1_byte == pwfs_pkg::ProtoLen);
    end else if (pos <= pwfs_pkg::ProtoLenPos) begin
      hc_new = hc && (s1_byte == pwfs_pkg::proto_char(char_idx));
    end else begin
      hc_new = hc;
    end

    if (pos < pwfs_pkg::PrefixBytesPos) begin
      prefix_next = {(is_first ? 24'd0 : prefix[23:0]), s1_byte};
    end else begin
      prefix_next = prefix;
    end

    last_hs = hc_new && (pos == pwfs_pkg::HandshakeLastPos);
    // at offset 3 the end equals the offset only for a zero prefix (keep-alive)
    if (pos == pwfs_pkg::PrefixLastPos) begin
      last_len = !hc_new && (prefix_next == '0);
    end else begin
      last_len = !hc_new && (pos > pwfs_pkg::PrefixLastPos) && (pos == end_pos);
    end
    is_last  = last_hs || last_len;
    pos_next = is_last ? '0 : pos + 33'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      pos       <= '0;
      hc        <= 1'b0;
    end else begin
      if (!s1_valid || advance) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
      if (advance && s1_valid) begin
        pos <= pos_next;
        hc  <= is_last ? 1'b0 : hc_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= rx_byte;
    end
    if (advance && s1_valid) begin
      prefix      <= prefix_next;
      out_byte    <= s1_byte;
      frame_first <= is_first;
      frame_last  <= is_last;
      frame_kind  <= last_hs;
      if (pos == pwfs_pkg::PrefixLastPos) begin
        end_pos <= {1'b0, prefix_next} + pwfs_pkg::PrefixLastPos;
      end
    end
  end

  a_kind_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_kind |-> frame_last)
    else $error("frame kind set on a byte that does not end a frame");

  a_no_candidate_at_start: assert property (@(posedge clk) disable iff (rst)
    pos == '0 |-> !hc)
    else $error("handshake candidate left over at a frame start");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("input stalled while the pipeline has room");

endmodule

`default_nettype wire

// ===== dv/peer_wire_frame_splitter_test.sv =====
// self-checking testbench of the peer-wire frame splitter with a directed table and random frames
`timescale 1ns / 100ps

module peer_wire_frame_splitter_test;

  localparam logic [8*19-1:0] ProtoText = "BitTorrent protocol";
  localparam int RandomItems = 1850;
  localparam int CalmItems = 200;
  localparam int WatchdogLimit = 1000;
  localparam int DirRows = 26;

  // typed, first, last, kind
  localparam logic [3:0] RowFirst = 4'b1100;
  localparam logic [3:0] RowMid = 4'b1000;
  localparam logic [3:0] RowEnd = 4'b1010;
  localparam logic [3:0] RowFree = 4'b0000;

  typedef struct packed {
    logic [7:0] data;
    logic       typed;
    logic       first;
    logic       last;
    logic       kind;
  } stim_t;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       kind;
  } marks_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       frame_first;
  logic       frame_last;
  logic       frame_kind;

  stim_t      wire_bytes_q [$];
  marks_t     frame_marks_q [$];
  logic       calm;
  int         errors;
  int         idle_cycles;
  int         stall_left;

  logic [32:0] trk_pos;
  logic [31:0] trk_prefix;
  logic        trk_handshake;

  stim_t dir_table [DirRows] = '{
    // keep-alive
    {8'h00, RowFirst}, {8'h00, RowMid}, {8'h00, RowMid}, {8'h00, RowEnd},
    // one payload byte at the top value
    {8'h00, RowFirst}, {8'h00, RowMid}, {8'h00, RowMid}, {8'h01, RowMid}, {8'hff, RowEnd},
    // two payload bytes
    {8'h00, RowFirst}, {8'h00, RowFree}, {8'h00, RowFree}, {8'h02, RowFree},
    {8'h80, RowFree}, {8'h00, RowEnd},
    // handshake-like bytes inside a payload
    {8'h00, RowFirst}, {8'h00, RowFree}, {8'h00, RowFree}, {8'h03, RowFree},
    {8'h13, RowFree}, {8'h42, RowFree}, {8'h69, RowFree},
    // keep-alive
    {8'h00, RowFirst}, {8'h00, RowFree}, {8'h00, RowFree}, {8'h00, RowEnd}
  };

  peer_wire_frame_splitter DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .frame_first (frame_first),
    .frame_last  (frame_last),
    .frame_kind  (frame_kind)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic logic [7:0] proto_byte(input int idx);
    return ProtoText[8*(18-idx) +: 8];
  endfunction

  task automatic frame_track(input logic [7:0] b, output marks_t m);
    m.data = b;
    m.first = (trk_pos == 33'd0);
    m.last = 1'b0;
    m.kind = 1'b0;
    if (trk_pos == 33'd0) begin
      trk_handshake = (b == 8'd19);
    end else if (trk_pos <= 33'd19) begin
      if (trk_handshake && b != proto_byte(int'(trk_pos) - 1)) begin
        trk_handshake = 1'b0;
      end
    end
    if (trk_pos < 33'd4) begin
      trk_prefix = (trk_pos == 33'd0) ? {24'd0, b} : {trk_prefix[23:0], b};
    end
    if (trk_handshake && trk_pos >= 33'd19) begin
      if (trk_pos == 33'd67) begin
        m.last = 1'b1;
        m.kind = 1'b1;
      end
    end else if (!trk_handshake && trk_pos >= 33'd3) begin
      if (trk_pos == {1'b0, trk_prefix} + 33'd3) begin
        m.last = 1'b1;
      end
    end
    if (m.last) begin
      trk_pos = 33'd0;
      trk_handshake = 1'b0;
    end else begin
      trk_pos = trk_pos + 33'd1;
    end
  endtask

  task automatic push_byte(input logic [7:0] b);
    wire_bytes_q.push_back({b, RowFree});
  endtask

  task automatic push_random(input int n);
    for (int i = 0; i < n; i++) begin
      push_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic queue_frame();
    int sel;
    int len;
    sel = $urandom_range(0, 9);
    if (sel < 2) begin
      repeat (4) push_byte(8'h00);
    end else if (sel < 4) begin
      push_byte(8'd19);
      for (int i = 0; i < 19; i++) push_byte(proto_byte(i));
      push_random(48);
    end else begin
      if ($urandom_range(0, 7) == 0) len = $urandom_range(25, 300);
      else len = $urandom_range(1, 24);
      push_byte(8'h00);
      push_byte(8'h00);
      push_byte(8'(len >> 8));
      push_byte(8'(len));
      push_random(len);
    end
  endtask

  // frame that never ends within the run
  task automatic queue_open_frame();
    int good;
    if ($urandom_range(0, 1) == 0) begin
      good = $urandom_range(0, 18);
      push_byte(8'd19);
      for (int i = 0; i < good; i++) push_byte(proto_byte(i));
      push_byte(proto_byte(good) ^ 8'($urandom_range(1, 255)));
    end else begin
      repeat (4) push_byte(8'hff);
    end
    push_random(40);
  endtask

  always @(posedge clk) begin
    if (rst || calm) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    marks_t m;
    if (!rst && out_valid && !out_stall) begin
      if (frame_marks_q.size() == 0) begin
        $error("unexpected output transaction, out_byte %0h", out_byte);
        errors++;
      end else begin
        m = frame_marks_q.pop_front();
        if (out_byte !== m.data) begin
          $error("out_byte: expected %0h, actual %0h", m.data, out_byte);
          errors++;
        end
        if (frame_first !== m.first) begin
          $error("frame_first: expected %0b, actual %0b", m.first, frame_first);
          errors++;
        end
        if (frame_last !== m.last) begin
          $error("frame_last: expected %0b, actual %0b", m.last, frame_last);
          errors++;
        end
        if (frame_kind !== m.kind) begin
          $error("frame_kind: expected %0b, actual %0b", m.kind, frame_kind);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WatchdogLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    stim_t  item;
    marks_t m;
    int     total;
    rst = 1'b1;
    in_valid = 1'b0;
    rx_byte = 8'h00;
    out_stall = 1'b0;
    calm = 1'b0;
    errors = 0;
    idle_cycles = 0;
    stall_left = 0;
    trk_pos = '0;
    trk_prefix = '0;
    trk_handshake = 1'b0;

    for (int i = 0; i < DirRows; i++) wire_bytes_q.push_back(dir_table[i]);
    while (wire_bytes_q.size() < DirRows + RandomItems - 60) queue_frame();
    queue_open_frame();
    total = wire_bytes_q.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < total; i++) begin
      item = wire_bytes_q[i];
      calm = (i >= total - CalmItems);
      if (!calm && $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      in_valid <= 1'b1;
      rx_byte <= item.data;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      frame_track(item.data, m);
      if (item.typed) m = {item.data, item.first, item.last, item.kind};
      frame_marks_q.push_back(m);
    end
    in_valid <= 1'b0;

    while (frame_marks_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/pwfs_pkg.sv
rtl/core/peer_wire_frame_splitter.sv
dv/peer_wire_frame_splitter_test.sv
